>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check prop at every clock edge outside reset.
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check prop at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/core/tfg_pkg.sv
// ----------------------------------------------------------------------------
// Turret fire gate package
// Widths, constants, stage types and per-stage step functions.
// ----------------------------------------------------------------------------
package tfg_pkg;

  localparam int ANGLE_FRAC_BITS = 13;
  localparam int OFFSET_BITS     = 20;

  localparam int ANG_W     = 16;
  localparam int WRAP_W    = ANG_W + 3;
  localparam int DIST_W    = 16;
  localparam int SIZE_W    = 10;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TOL_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_HEIGHT = 2'd2;

  localparam logic [CFG_W-1:0] TOL_RATE_RST   = 10'd256;
  localparam logic [CFG_W-1:0] DEF_WIDTH_RST  = 10'd135;
  localparam logic [CFG_W-1:0] DEF_HEIGHT_RST = 10'd125;

  // pi/2 in Q30, rounded to nearest in the angle format
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint HALF_PI_FIX =
    (HALF_PI_Q30 + (64'sd1 << (29 - ANGLE_FRAC_BITS))) / (64'sd1 << (30 - ANGLE_FRAC_BITS));
  localparam logic signed [WRAP_W-1:0] HP_C     = WRAP_W'(HALF_PI_FIX);
  localparam logic signed [WRAP_W-1:0] PI_C     = WRAP_W'(2 * HALF_PI_FIX);
  localparam logic signed [WRAP_W-1:0] TWO_PI_C = WRAP_W'(4 * HALF_PI_FIX);

  localparam int CORDIC_STEPS = 28;
  localparam int XY_W    = 33;
  localparam int Z_W     = 33;
  localparam int Z_SHIFT = 30 - ANGLE_FRAC_BITS;
  localparam logic signed [XY_W-1:0] ONE_Q30 = XY_W'(64'sd1 << 30);

  localparam int GAIN_W = 30;
  localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;
  localparam int C_W    = 31;
  localparam int D_W    = 31;
  localparam int NUM_W  = DIST_W + D_W + 8;
  localparam int Q_W    = OFFSET_BITS + 9;
  localparam int DIV_W  = D_W + Q_W;
  localparam int LIM_W  = 2 * SIZE_W;
  localparam int MM_W   = Q_W - 7;
  localparam int SQ_W   = 2 * OFFSET_BITS + 1;
  localparam int ROOT_W = OFFSET_BITS + 1;
  localparam int TR_W   = SQ_W + 2;
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

  typedef struct packed {
    logic signed [ANG_W-1:0]  target_yaw;
    logic signed [ANG_W-1:0]  target_pitch;
    logic [DIST_W-1:0]        target_distance_mm;
    logic signed [ANG_W-1:0]  gimbal_yaw;
    logic signed [ANG_W-1:0]  gimbal_pitch;
    logic [SIZE_W-1:0]        plate_width_mm;
    logic [SIZE_W-1:0]        plate_height_mm;
    logic signed [ANG_W-1:0]  plate_facing;
  } in_item_t;

  typedef struct packed {
    logic                     fire_ok;
    logic                     gate_ok;
    logic                     yaw_ok;
    logic                     elev_ok;
    logic [OFFSET_BITS-1:0]   yaw_offset_mm;
    logic [OFFSET_BITS-1:0]   pitch_offset_mm;
    logic [OFFSET_BITS-1:0]   tracking_error_mm;
  } out_item_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } rot_t;

  typedef struct packed {
    logic              rej;
    logic [DIST_W-1:0] rng_mm;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    rot_t              ry;
    rot_t              rp;
    rot_t              rf;
  } cor_t;

  typedef struct packed {
    logic             rej;
    logic [NUM_W-1:0] ny;
    logic [D_W-1:0]   dy;
    logic [NUM_W-1:0] np;
    logic [D_W-1:0]   dp;
    logic [C_W-1:0]   c;
    logic [LIM_W-1:0] we;
    logic [LIM_W-1:0] he;
  } mul_t;

  typedef struct packed {
    logic             sat;
    logic [NUM_W-1:0] r;
    logic [D_W-1:0]   d;
    logic [Q_W-1:0]   q;
  } dl_t;

  typedef struct packed {
    logic             rej;
    logic [LIM_W-1:0] ylim;
    logic [LIM_W-1:0] plim;
    dl_t              ly;
    dl_t              lp;
  } div_t;

  typedef struct packed {
    logic                   rej;
    logic                   yok;
    logic                   pok;
    logic [OFFSET_BITS-1:0] ymm;
    logic [OFFSET_BITS-1:0] pmm;
  } chk_t;

  typedef struct packed {
    chk_t                     k;
    logic [2*OFFSET_BITS-1:0] a2;
    logic [2*OFFSET_BITS-1:0] b2;
  } sqr_t;

  typedef struct packed {
    chk_t              k;
    logic [SQ_W-1:0]   res;
    logic [ROOT_W-1:0] root;
  } rt_t;

  function automatic logic [31:0] atan_q30(int i);
    logic [31:0] a;
    case (i)
      0:  a = 32'h3243F6A8;
      1:  a = 32'h1DAC6705;
      2:  a = 32'h0FADBAFC;
      3:  a = 32'h07F56EA6;
      4:  a = 32'h03FEAB76;
      5:  a = 32'h01FFD55B;
      6:  a = 32'h00FFFAAA;
      7:  a = 32'h007FFF55;
      8:  a = 32'h003FFFEA;
      9:  a = 32'h001FFFFD;
      10: a = 32'h000FFFFF;
      11: a = 32'h0007FFFF;
      12: a = 32'h0003FFFF;
      13: a = 32'h0001FFFF;
      14: a = 32'h0000FFFF;
      15: a = 32'h00007FFF;
      16: a = 32'h00003FFF;
      17: a = 32'h00001FFF;
      18: a = 32'h00000FFF;
      19: a = 32'h000007FF;
      20: a = 32'h000003FF;
      21: a = 32'h000001FF;
      22: a = 32'h000000FF;
      23: a = 32'h0000007F;
      24: a = 32'h0000003F;
      25: a = 32'h0000001F;
      26: a = 32'h0000000F;
      27: a = 32'h00000008;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

  // One rotation micro-step, direction from the sign of the residual angle.
  function automatic rot_t cordic_step(rot_t s, int i);
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  a;
    rot_t                   r;
    dx = s.y >>> i;
    dy = s.x >>> i;
    a  = $signed({1'b0, atan_q30(i)});
    if (!s.z[Z_W-1]) begin
      r.x = s.x - dx;
      r.y = s.y + dy;
      r.z = s.z - a;
    end else begin
      r.x = s.x + dx;
      r.y = s.y - dy;
      r.z = s.z + a;
    end
    return r;
  endfunction

  function automatic rot_t cordic_init(logic signed [WRAP_W-1:0] ang);
    rot_t r;
    r.x = ONE_Q30;
    r.y = '0;
    r.z = Z_W'(ang) <<< Z_SHIFT;
    return r;
  endfunction

  // Restoring division, quotient bit k.
  function automatic dl_t div_step(dl_t l, int k);
    logic [DIV_W-1:0] t;
    dl_t              o;
    o = l;
    t = DIV_W'(l.d) << k;
    if (DIV_W'(l.r) >= t) begin
      o.r    = l.r - t[NUM_W-1:0];
      o.q[k] = 1'b1;
    end
    return o;
  endfunction

  // Digit-by-digit square root, root bit k.
  function automatic rt_t rt_step(rt_t s, int k);
    logic [TR_W-1:0] t;
    rt_t             o;
    o = s;
    t = (TR_W'(s.root) << (k + 1)) + (TR_W'(1) << (2 * k));
    if (TR_W'(s.res) >= t) begin
      o.res     = s.res - t[SQ_W-1:0];
      o.root[k] = 1'b1;
    end
    return o;
  endfunction

  // Q8 millimetres to whole millimetres, round half up, saturate.
  function automatic logic [OFFSET_BITS-1:0] to_mm(logic [Q_W-1:0] q);
    logic [Q_W:0]    s;
    logic [MM_W-1:0] m;
    s = {1'b0, q} + (Q_W+1)'(128);
    m = s[Q_W:8];
    return (m > MM_W'(OFF_MAX)) ? OFF_MAX : m[OFFSET_BITS-1:0];
  endfunction

endpackage

>>> rtl/core/tfg_if.sv
// ----------------------------------------------------------------------------
// Turret fire gate channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface tfg_in_if;
  logic               valid;
  logic               ready;
  tfg_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tfg_out_if;
  logic               valid;
  logic               ready;
  tfg_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/turret_fire_gate.sv
// ----------------------------------------------------------------------------
// Turret fire gate
// Decides per aim item whether the turret may fire, and reports miss offsets.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one aim item per transfer (target and gimbal angles, distance,
//   plate size and facing); out_o carries one result per item, in order.
//   The config port writes the tolerance rate, default plate width and height;
//   the user must write them only while the block is idle, and the block itself
//   leaves this unchecked. Register index 3 is ignored.
// Throughput: one item per cycle whenever the pipeline advances. Every step is
//   one register stage: 28 CORDIC micro-rotations, 29 quotient bits of the
//   restoring divider and 21 root bits of the square root set the depth.
// Stall: the whole pipeline advances together whenever the output register is
//   empty or being taken; when ready is low with a result waiting, every stage
//   holds and in_i.ready drops in the same cycle, so nothing is lost or repeated.
// Reset: rst_ni clears all valid bits and loads the config defaults
//   (tolerance rate 256, width 135 mm, height 125 mm).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module turret_fire_gate (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tfg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tfg_pkg::CFG_W-1:0]       cfg_data_i,
  tfg_in_if.sink                          in_i,
  tfg_out_if.source                       out_o
);

  localparam int NC = tfg_pkg::CORDIC_STEPS;
  localparam int NQ = tfg_pkg::Q_W;
  localparam int NR = tfg_pkg::ROOT_W;

  // Config registers
  logic [tfg_pkg::CFG_W-1:0] err_rate_q, def_w_q, def_h_q;

  // Stage registers and valid bits
  tfg_pkg::cor_t      cor_q [NC+1];
  tfg_pkg::cor_t      cor_d [NC+1];
  logic [NC:0]        cor_v_q;
  tfg_pkg::mul_t      mul_q, mul_d;
  logic               mul_v_q;
  tfg_pkg::div_t      div_q [NQ+1];
  tfg_pkg::div_t      div_d [NQ+1];
  logic [NQ:0]        div_v_q;
  tfg_pkg::chk_t      chk_q, chk_d;
  logic               chk_v_q;
  tfg_pkg::sqr_t      sqr_q, sqr_d;
  logic               sqr_v_q;
  tfg_pkg::rt_t       rt_q [NR+1];
  tfg_pkg::rt_t       rt_d [NR+1];
  logic [NR:0]        rt_v_q;
  tfg_pkg::out_item_t out_q, out_d;
  logic               out_v_q;

  logic adv;

  // Advance when the output slot is free or its transfer completes.
  assign adv         = !out_v_q || out_o.ready;
  assign in_i.ready  = adv;
  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_rate_q <= tfg_pkg::TOL_RATE_RST;
      def_w_q    <= tfg_pkg::DEF_WIDTH_RST;
      def_h_q    <= tfg_pkg::DEF_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tfg_pkg::CFG_TOL_RATE:   err_rate_q <= cfg_data_i;
        tfg_pkg::CFG_DEF_WIDTH:  def_w_q    <= cfg_data_i;
        tfg_pkg::CFG_DEF_HEIGHT: def_h_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits move as one shift chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cor_v_q <= '0;
      mul_v_q <= 1'b0;
      div_v_q <= '0;
      chk_v_q <= 1'b0;
      sqr_v_q <= 1'b0;
      rt_v_q  <= '0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      cor_v_q <= {cor_v_q[NC-1:0], in_i.valid};
      mul_v_q <= cor_v_q[NC];
      div_v_q <= {div_v_q[NQ-1:0], mul_v_q};
      chk_v_q <= div_v_q[NQ];
      sqr_v_q <= chk_v_q;
      rt_v_q  <= {rt_v_q[NR-1:0], sqr_v_q};
      out_v_q <= rt_v_q[NR];
    end
  end

  // Front stage: wrap yaw error, reject wide errors, fold facing, pick sizes.
  always_comb begin
    logic signed [tfg_pkg::WRAP_W-1:0] ye0, ye, pe, f0, f;
    ye0 = tfg_pkg::WRAP_W'(in_i.data.target_yaw) - tfg_pkg::WRAP_W'(in_i.data.gimbal_yaw);
    pe  = tfg_pkg::WRAP_W'(in_i.data.target_pitch) - tfg_pkg::WRAP_W'(in_i.data.gimbal_pitch);
    f0  = tfg_pkg::WRAP_W'(in_i.data.plate_facing);
    if (ye0 > tfg_pkg::PI_C) begin
      ye = ye0 - tfg_pkg::TWO_PI_C;
    end else if (ye0 <= -tfg_pkg::PI_C) begin
      ye = ye0 + tfg_pkg::TWO_PI_C;
    end else begin
      ye = ye0;
    end
    if (f0 > tfg_pkg::HP_C) begin
      f = f0 - tfg_pkg::PI_C;
    end else if (f0 < -tfg_pkg::HP_C) begin
      f = f0 + tfg_pkg::PI_C;
    end else begin
      f = f0;
    end
    cor_d[0].rej    = (ye >= tfg_pkg::HP_C) || (ye <= -tfg_pkg::HP_C) ||
                      (pe >= tfg_pkg::HP_C) || (pe <= -tfg_pkg::HP_C);
    cor_d[0].rng_mm = in_i.data.target_distance_mm;
    cor_d[0].w      = (in_i.data.plate_width_mm == '0) ? def_w_q : in_i.data.plate_width_mm;
    cor_d[0].h      = (in_i.data.plate_height_mm == '0) ? def_h_q : in_i.data.plate_height_mm;
    cor_d[0].ry     = tfg_pkg::cordic_init(ye);
    cor_d[0].rp     = tfg_pkg::cordic_init(pe);
    cor_d[0].rf     = tfg_pkg::cordic_init(f);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cor_q[0] <= cor_d[0];
    end
  end

  // CORDIC: one micro-rotation per stage on all three angles.
  for (genvar gi = 0; gi < NC; gi++) begin : g_cor
    always_comb begin
      cor_d[gi+1]    = cor_q[gi];
      cor_d[gi+1].ry = tfg_pkg::cordic_step(cor_q[gi].ry, gi);
      cor_d[gi+1].rp = tfg_pkg::cordic_step(cor_q[gi].rp, gi);
      cor_d[gi+1].rf = tfg_pkg::cordic_step(cor_q[gi].rf, gi);
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        cor_q[gi+1] <= cor_d[gi+1];
      end
    end
  end

  // Multiply stage: dividends dist*|sin|*256, cosine divisors, |cos(facing)|, size limits.
  always_comb begin
    tfg_pkg::cor_t                          s;
    logic [tfg_pkg::XY_W-1:0]               ayy, ayp;
    logic [tfg_pkg::DIST_W+tfg_pkg::D_W-1:0] py, pp;
    logic [tfg_pkg::C_W+tfg_pkg::GAIN_W-1:0] pc;
    s   = cor_q[NC];
    ayy = s.ry.y[tfg_pkg::XY_W-1] ? -s.ry.y : s.ry.y;
    ayp = s.rp.y[tfg_pkg::XY_W-1] ? -s.rp.y : s.rp.y;
    py  = (tfg_pkg::DIST_W+tfg_pkg::D_W)'(s.rng_mm) *
          (tfg_pkg::DIST_W+tfg_pkg::D_W)'(ayy[tfg_pkg::D_W-1:0]);
    pp  = (tfg_pkg::DIST_W+tfg_pkg::D_W)'(s.rng_mm) *
          (tfg_pkg::DIST_W+tfg_pkg::D_W)'(ayp[tfg_pkg::D_W-1:0]);
    pc  = (tfg_pkg::C_W+tfg_pkg::GAIN_W)'(s.rf.x[tfg_pkg::D_W-1:0]) *
          (tfg_pkg::C_W+tfg_pkg::GAIN_W)'(tfg_pkg::GAIN_Q30) +
          (tfg_pkg::C_W+tfg_pkg::GAIN_W)'(64'd1 << 29);
    mul_d.rej = s.rej;
    mul_d.ny  = {py, 8'd0};
    mul_d.np  = {pp, 8'd0};
    // Hold the divisor at one when the cosine is not positive.
    mul_d.dy  = (!s.ry.x[tfg_pkg::XY_W-1] && s.ry.x != '0) ?
                s.ry.x[tfg_pkg::D_W-1:0] : tfg_pkg::D_W'(1);
    mul_d.dp  = (!s.rp.x[tfg_pkg::XY_W-1] && s.rp.x != '0) ?
                s.rp.x[tfg_pkg::D_W-1:0] : tfg_pkg::D_W'(1);
    mul_d.c   = (!s.rf.x[tfg_pkg::XY_W-1] && s.rf.x != '0) ?
                pc[tfg_pkg::C_W+tfg_pkg::GAIN_W-1:30] : '0;
    mul_d.we  = tfg_pkg::LIM_W'(s.w) * tfg_pkg::LIM_W'(err_rate_q);
    mul_d.he  = tfg_pkg::LIM_W'(s.h) * tfg_pkg::LIM_W'(err_rate_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mul_q <= mul_d;
    end
  end

  // Limit stage: scale the yaw limit by |cos|, flag quotient overflow.
  always_comb begin
    logic [tfg_pkg::LIM_W+tfg_pkg::C_W-1:0] pl;
    pl            = (tfg_pkg::LIM_W+tfg_pkg::C_W)'(mul_q.we) *
                    (tfg_pkg::LIM_W+tfg_pkg::C_W)'(mul_q.c);
    div_d[0].rej  = mul_q.rej;
    div_d[0].ylim = pl[tfg_pkg::LIM_W+tfg_pkg::C_W-1:31];
    div_d[0].plim = mul_q.he >> 1;
    div_d[0].ly.sat = tfg_pkg::DIV_W'(mul_q.ny) >= {mul_q.dy, {NQ{1'b0}}};
    div_d[0].ly.r   = mul_q.ny;
    div_d[0].ly.d   = mul_q.dy;
    div_d[0].ly.q   = '0;
    div_d[0].lp.sat = tfg_pkg::DIV_W'(mul_q.np) >= {mul_q.dp, {NQ{1'b0}}};
    div_d[0].lp.r   = mul_q.np;
    div_d[0].lp.d   = mul_q.dp;
    div_d[0].lp.q   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_q[0] <= div_d[0];
    end
  end

  // Divider: one quotient bit per stage, MSB first.
  for (genvar gj = 0; gj < NQ; gj++) begin : g_div
    always_comb begin
      div_d[gj+1]    = div_q[gj];
      div_d[gj+1].ly = tfg_pkg::div_step(div_q[gj].ly, NQ - 1 - gj);
      div_d[gj+1].lp = tfg_pkg::div_step(div_q[gj].lp, NQ - 1 - gj);
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_q[gj+1] <= div_d[gj+1];
      end
    end
  end

  // Check stage: compare Q8 offsets to limits, round to mm.
  always_comb begin
    logic [tfg_pkg::Q_W-1:0] qy, qp;
    qy = div_q[NQ].ly.sat ? '1 : div_q[NQ].ly.q;
    qp = div_q[NQ].lp.sat ? '1 : div_q[NQ].lp.q;
    chk_d.rej = div_q[NQ].rej;
    chk_d.yok = !div_q[NQ].rej && (qy < tfg_pkg::Q_W'(div_q[NQ].ylim));
    chk_d.pok = !div_q[NQ].rej && (qp < tfg_pkg::Q_W'(div_q[NQ].plim));
    chk_d.ymm = div_q[NQ].rej ? '0 : tfg_pkg::to_mm(qy);
    chk_d.pmm = div_q[NQ].rej ? '0 : tfg_pkg::to_mm(qp);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      chk_q <= chk_d;
    end
  end

  always_comb begin
    sqr_d.k  = chk_q;
    sqr_d.a2 = (2*tfg_pkg::OFFSET_BITS)'(chk_q.ymm) * (2*tfg_pkg::OFFSET_BITS)'(chk_q.ymm);
    sqr_d.b2 = (2*tfg_pkg::OFFSET_BITS)'(chk_q.pmm) * (2*tfg_pkg::OFFSET_BITS)'(chk_q.pmm);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqr_q <= sqr_d;
    end
  end

  always_comb begin
    rt_d[0].k    = sqr_q.k;
    rt_d[0].res  = tfg_pkg::SQ_W'(sqr_q.a2) + tfg_pkg::SQ_W'(sqr_q.b2);
    rt_d[0].root = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rt_q[0] <= rt_d[0];
    end
  end

  // Square root: one root bit per stage, MSB first.
  for (genvar gk = 0; gk < NR; gk++) begin : g_rt
    always_comb begin
      rt_d[gk+1] = tfg_pkg::rt_step(rt_q[gk], NR - 1 - gk);
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rt_q[gk+1] <= rt_d[gk+1];
      end
    end
  end

  // Output stage: round the root to nearest, saturate, force reject code.
  always_comb begin
    logic [NR:0] rnd;
    rnd = {1'b0, rt_q[NR].root} +
          (NR+1)'(rt_q[NR].res > tfg_pkg::SQ_W'(rt_q[NR].root));
    out_d.fire_ok         = rt_q[NR].k.yok && rt_q[NR].k.pok;
    out_d.gate_ok         = !rt_q[NR].k.rej;
    out_d.yaw_ok          = rt_q[NR].k.yok;
    out_d.elev_ok         = rt_q[NR].k.pok;
    out_d.yaw_offset_mm   = rt_q[NR].k.ymm;
    out_d.pitch_offset_mm = rt_q[NR].k.pmm;
    if (rt_q[NR].k.rej || rnd > (NR+1)'(tfg_pkg::OFF_MAX)) begin
      out_d.tracking_error_mm = tfg_pkg::OFF_MAX;
    end else begin
      out_d.tracking_error_mm = rnd[tfg_pkg::OFFSET_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  // Assertions
  `ASSERT_RST(a_stall_keeps_items, clk_i, rst_ni, !adv |=> $countones({cor_v_q, mul_v_q, div_v_q, chk_v_q, sqr_v_q, rt_v_q, out_v_q}) == $past($countones({cor_v_q, mul_v_q, div_v_q, chk_v_q, sqr_v_q, rt_v_q, out_v_q})), "pipeline item count changed during a stall")
  `ASSERT_RST(a_accept_enters, clk_i, rst_ni, (in_i.valid && in_i.ready) |=> cor_v_q[0], "accepted item did not enter the front stage")
  `ASSERT_RST(a_reject_code, clk_i, rst_ni, (out_o.valid && !out_o.data.gate_ok) |-> (out_o.data.tracking_error_mm == tfg_pkg::OFF_MAX && out_o.data.yaw_offset_mm == '0 && out_o.data.pitch_offset_mm == '0), "rejected item carries offsets")
  `ASSERT_RST(a_flags_need_angle, clk_i, rst_ni, (out_o.valid && (out_o.data.yaw_ok || out_o.data.elev_ok || out_o.data.fire_ok)) |-> out_o.data.gate_ok, "check flag set on rejected angle")
  `ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !out_o.valid, "result offered during reset")

endmodule
